@@ hdl/u8cpd_pkg.sv @@
// Shared types and constants for the UTF-8 code point decoder.
package u8cpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned PEND_W   = 2;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT    = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_MIN       = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_MIN      = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN      = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_LIMIT     = 8'hF5;
  localparam logic [BYTE_W-1:0] LEAD_E0        = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_ED        = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD_F0        = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F4        = 8'hF4;
  localparam logic [BYTE_W-1:0] CONT_LOW       = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_HIGH      = 8'hBF;
  localparam logic [BYTE_W-1:0] E0_LOW         = 8'hA0;
  localparam logic [BYTE_W-1:0] ED_HIGH        = 8'h9F;
  localparam logic [BYTE_W-1:0] F0_LOW         = 8'h90;
  localparam logic [BYTE_W-1:0] F4_HIGH        = 8'h8F;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    logic               replaced;
    logic               last;
    logic               ends_string;
  } out_t;

endpackage

@@ hdl/utf8_codepoint_decoder.sv @@
// UTF-8 decoder: one byte in, up to two code point results out, via a result queue.
// Each accepted byte writes its results into the registered result queue.
// Throughput: one byte per cycle while ready; results leave the queue singly.
// Ready is high while at least two result queue places are free (queue depth four).
// Reset (synchronous, rst high) closes any open sequence and empties the result queue.
module utf8_codepoint_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  u8cpd_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output u8cpd_pkg::out_t out_data
);
  import u8cpd_pkg::*;

  // decoder state
  logic [CP_W-1:0]    partial_value, partial_value_next;
  logic [PEND_W-1:0]  bytes_pending, bytes_pending_next;
  logic [COUNT_W-1:0] bytes_taken, bytes_taken_next;
  logic [BYTE_W-1:0]  second_byte_low, second_byte_low_next;
  logic [BYTE_W-1:0]  second_byte_high, second_byte_high_next;

  // result queue
  out_t                 queue [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0] fill, fill_next;

  logic in_fire, out_fire;

  // lead byte decode
  logic [BYTE_W-1:0]  b;
  logic               eos;
  logic               lead_emit;
  out_t               lead_res;
  logic [CP_W-1:0]    lead_partial;
  logic [PEND_W-1:0]  lead_pending;
  logic [COUNT_W-1:0] lead_taken;
  logic [BYTE_W-1:0]  lead_low, lead_high;

  // continuation decode
  logic [CP_W-1:0]   cont_add, cont_sum;
  logic [PEND_W-1:0] pend_dec;
  logic [COUNT_W-1:0] taken_inc;
  logic              in_range;

  out_t       res0, res1;
  logic [1:0] n_res;

  assign b   = in_data.in_byte;
  assign eos = in_data.end_of_string;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = fill <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign out_valid = fill != '0;
  assign out_data  = queue[rd_ptr];

  always_comb begin
    lead_emit    = 1'b0;
    lead_res     = '0;
    lead_partial = '0;
    lead_pending = '0;
    lead_taken   = '0;
    lead_low     = CONT_LOW;
    lead_high    = CONT_HIGH;
    if (b < ASCII_LIMIT) begin
      lead_emit           = 1'b1;
      lead_res.code_point = CP_W'(b);
      lead_res.byte_count = COUNT_W'(1);
    end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
      lead_emit           = 1'b1;
      lead_res.code_point = REPLACEMENT_CP;
      lead_res.byte_count = COUNT_W'(1);
      lead_res.replaced   = 1'b1;
    end else if (eos) begin
      // string ends on a lead byte: replace it and stay idle
      lead_emit           = 1'b1;
      lead_res.code_point = REPLACEMENT_CP;
      lead_res.byte_count = COUNT_W'(1);
      lead_res.replaced   = 1'b1;
    end else begin
      lead_taken = COUNT_W'(1);
      if (b < LEAD3_MIN) begin
        lead_pending = PEND_W'(1);
        lead_partial = {10'd0, b[4:0], 6'd0};
      end else if (b < LEAD4_MIN) begin
        lead_pending = PEND_W'(2);
        lead_partial = {5'd0, b[3:0], 12'd0};
        if (b == LEAD_E0) lead_low = E0_LOW;
        if (b == LEAD_ED) lead_high = ED_HIGH;
      end else begin
        lead_pending = PEND_W'(3);
        lead_partial = {b[2:0], 18'd0};
        if (b == LEAD_F0) lead_low = F0_LOW;
        if (b == LEAD_F4) lead_high = F4_HIGH;
      end
    end
  end

  always_comb begin
    // continuation bytes always lie in 80..BF here, so the payload is the low six bits
    case (bytes_pending)
      2'd2:    cont_add = {9'd0, b[5:0], 6'd0};
      2'd3:    cont_add = {3'd0, b[5:0], 12'd0};
      default: cont_add = {15'd0, b[5:0]};
    endcase
    cont_sum  = partial_value + cont_add;
    pend_dec  = bytes_pending - PEND_W'(1);
    taken_inc = bytes_taken + COUNT_W'(1);
    in_range  = b >= second_byte_low && b <= second_byte_high;
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    n_res = 2'd0;
    partial_value_next    = partial_value;
    bytes_pending_next    = bytes_pending;
    bytes_taken_next      = bytes_taken;
    second_byte_low_next  = second_byte_low;
    second_byte_high_next = second_byte_high;
    if (bytes_pending == '0) begin
      res0  = lead_res;
      n_res = lead_emit ? 2'd1 : 2'd0;
      partial_value_next    = lead_partial;
      bytes_pending_next    = lead_pending;
      bytes_taken_next      = lead_taken;
      second_byte_low_next  = lead_low;
      second_byte_high_next = lead_high;
    end else if (in_range) begin
      partial_value_next    = cont_sum;
      bytes_pending_next    = pend_dec;
      bytes_taken_next      = taken_inc;
      second_byte_low_next  = CONT_LOW;
      second_byte_high_next = CONT_HIGH;
      if (pend_dec == '0 || eos) begin
        n_res           = 2'd1;
        res0.byte_count = taken_inc;
        if (pend_dec == '0) begin
          res0.code_point = cont_sum;
        end else begin
          res0.code_point = REPLACEMENT_CP;
          res0.replaced   = 1'b1;
        end
        partial_value_next = '0;
        bytes_pending_next = '0;
        bytes_taken_next   = '0;
      end
    end else begin
      // broken sequence: replace what came before, then decode this byte afresh
      res0.code_point = REPLACEMENT_CP;
      res0.byte_count = bytes_taken;
      res0.replaced   = 1'b1;
      res1  = lead_res;
      n_res = lead_emit ? 2'd2 : 2'd1;
      partial_value_next    = lead_partial;
      bytes_pending_next    = lead_pending;
      bytes_taken_next      = lead_taken;
      second_byte_low_next  = lead_low;
      second_byte_high_next = lead_high;
    end
    // mark the final result of this byte
    if (n_res == 2'd2) begin
      res1.last        = 1'b1;
      res1.ends_string = eos;
    end else begin
      res0.last        = 1'b1;
      res0.ends_string = eos;
    end
  end

  always_comb begin
    fill_next = fill;
    if (in_fire) fill_next = fill_next + OUT_CNT_W'(n_res);
    if (out_fire) fill_next = fill_next - OUT_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value    <= '0;
      bytes_pending    <= '0;
      bytes_taken      <= '0;
      second_byte_low  <= CONT_LOW;
      second_byte_high <= CONT_HIGH;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      fill             <= '0;
    end else begin
      if (in_fire) begin
        partial_value    <= partial_value_next;
        bytes_pending    <= bytes_pending_next;
        bytes_taken      <= bytes_taken_next;
        second_byte_low  <= second_byte_low_next;
        second_byte_high <= second_byte_high_next;
        wr_ptr           <= wr_ptr + OUT_PTR_W'(n_res);
      end
      if (out_fire) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      fill <= fill_next;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) queue[wr_ptr] <= res0;
      if (n_res == 2'd2) queue[wr_ptr + OUT_PTR_W'(1)] <= res1;
    end
  end

endmodule

@@ hdl/u8cpd_checker.sv @@
// Port-level checks for the UTF-8 code point decoder, with its bind.
module u8cpd_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input u8cpd_pkg::out_t out_data
);
  import u8cpd_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_ends_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ends_string |-> out_data.last)
    else $error("string closed on a result that is not the last of its byte");

  a_replaced_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.replaced |-> out_data.code_point == REPLACEMENT_CP)
    else $error("replacement item without U+FFFD");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_count >= COUNT_W'(1) && out_data.byte_count <= COUNT_W'(4))
    else $error("byte count out of range");

  a_single_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.replaced && out_data.byte_count == COUNT_W'(1)
      |-> out_data.code_point < CP_W'(ASCII_LIMIT))
    else $error("one-byte code point above ASCII");

endmodule

bind utf8_codepoint_decoder u8cpd_checker u_u8cpd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
